// File: sv/dual_sensor_warning_fusion_assert.svh
// Assertion macros shared by the fusion block modules.
`ifndef DUAL_SENSOR_WARNING_FUSION_ASSERT_SVH
`define DUAL_SENSOR_WARNING_FUSION_ASSERT_SVH

// Implication in the same cycle, checked on every clock edge outside reset.
`define DSWF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication into the following cycle.
`define DSWF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/dswf_pkg.sv
// Package with types, codes and constants of the dual sensor warning fusion block.
`timescale 1ns / 1ps
package dswf_pkg;

  localparam int FRAME_COUNT_BITS_DEF = 32;

  localparam logic [1:0] OP_FRONT = 2'd0;
  localparam logic [1:0] OP_REAR  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] LVL_SAFE   = 2'd0;
  localparam logic [1:0] LVL_DANGER = 2'd2;

  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_STOP_EN  = 2'd1;
  localparam logic [1:0] REG_DANGER   = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE = 2'd3;

  localparam int CFG_W = 17;
  localparam logic [16:0] SAFE_DIST_CM = 17'd99900;

  localparam logic [15:0] TIMEOUT_RST  = 16'd500;
  localparam logic [16:0] DANGER_RST   = 17'd300;
  localparam logic [7:0]  DEBOUNCE_RST = 8'd2;

  // Confidence divider: quotient bits 10 down to 0, bit 10 only flags saturation.
  localparam int NUM_W     = 27;
  localparam int Q_W       = 11;
  localparam int DIV_STEPS = 11;
  localparam int STEP_W    = 4;
  localparam logic [9:0] PERMILLE   = 10'd1000;
  localparam logic [9:0] CONF_CLAMP = 10'd500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] time_ms;
    logic [1:0]  sample_level;
    logic [16:0] sample_dist_cm;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  fused_level;
    logic [16:0] fused_dist_cm;
    logic        warning_flag;
    logic        front_chosen;
    logic        stop_flag;
    logic        stop_reason;
    logic [9:0]  confidence_permille;
    logic        front_silent;
    logic        rear_silent;
  } out_item_t;

  typedef struct packed {
    logic store_front;
    logic store_rear;
    logic capture;
    logic eval;
    logic load;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: sv/dswf_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
`timescale 1ns / 1ps
interface dswf_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: sv/dual_sensor_warning_fusion.sv
// Top level of the dual sensor warning fusion block.
//
// The input channel carries front samples, rear samples and ticks, each with a
// millisecond time stamp. A sample is stored in the cycle it is accepted and
// gives no result; an unknown operation is dropped. A tick gives exactly one
// result beat on the output channel.
// A tick passes through evaluation, operand load, the 11-step serial divider
// that forms the confidence ratio and result load, and the input is ready again
// in the cycle in which its result turns valid.
// The result sits in an output register, so a stalled receiver does not stop
// the next item from being accepted; a later tick waits at its last step until
// the register is free.
// Configuration writes are taken in any cycle and apply to the next items.
// Reset is synchronous: both sides become unseen, the debounce run and frame
// key clear, and the registers return to their reset values.
`timescale 1ns / 1ps
module dual_sensor_warning_fusion #(
  parameter int FRAME_COUNT_BITS = dswf_pkg::FRAME_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  dswf_chan_if.sink   in_ch,
  dswf_chan_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import dswf_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  assign in_item        = in_ch.payload;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  dswf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .op       (in_item.operation),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  dswf_dp #(
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );
endmodule

// File: sv/dswf_ctrl.sv
// Controller state machine sequencing sample stores, tick evaluation and the divider.
`timescale 1ns / 1ps
`include "dual_sensor_warning_fusion_assert.svh"
module dswf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           op,
  output logic                 in_ready,
  output dswf_pkg::ctrl_cmd_t  cmd,
  input  dswf_pkg::ctrl_sts_t  sts
);
  import dswf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && op == OP_TICK) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op)
            OP_FRONT: cmd.store_front = 1'b1;
            OP_REAR:  cmd.store_rear  = 1'b1;
            OP_TICK:  cmd.capture     = 1'b1;
            default:  cmd             = '0;
          endcase
        end
      end
      ST_EVAL: cmd.eval = 1'b1;
      ST_LOAD: cmd.load = 1'b1;
      ST_DIV:  cmd.step = 1'b1;
      ST_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  `DSWF_ASSERT_NEXT(a_tick_starts_eval, cmd.capture, state == ST_EVAL, "tick did not start evaluation")
  `DSWF_ASSERT_IMP(a_load_when_free, cmd.out_load, sts.out_free, "result loaded over a pending beat")
endmodule

// File: sv/dswf_dp.sv
// Datapath with side stores, fusion, debounce, serial confidence divider and result register.
`timescale 1ns / 1ps
`include "dual_sensor_warning_fusion_assert.svh"
module dswf_dp #(
  parameter int FRAME_COUNT_BITS = dswf_pkg::FRAME_COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dswf_pkg::in_item_t   in_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [16:0]          cfg_data,
  input  dswf_pkg::ctrl_cmd_t  cmd,
  output dswf_pkg::ctrl_sts_t  sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dswf_pkg::out_item_t  out_item
);
  import dswf_pkg::*;

  logic [15:0] timeout_ms;
  logic        stop_enable;
  logic [16:0] danger_dist_cm;
  logic [7:0]  debounce_frames;

  logic [1:0]                  front_level;
  logic [16:0]                 front_dist;
  logic [31:0]                 front_stamp;
  logic [FRAME_COUNT_BITS-1:0] front_count;
  logic                        front_seen;
  logic [1:0]                  rear_level;
  logic [16:0]                 rear_dist;
  logic [31:0]                 rear_stamp;
  logic [FRAME_COUNT_BITS-1:0] rear_count;
  logic                        rear_seen;

  logic [7:0]                  danger_run;
  logic [FRAME_COUNT_BITS:0]   counted_key;

  logic        front_silent;
  logic        rear_silent;
  logic [1:0]  win_level;
  logic [16:0] win_dist;
  logic        front_won;

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  divisor;
  logic [Q_W-1:0]    quot;
  logic [STEP_W-1:0] step_cnt;

  logic [1:0]  lvl_sat;
  logic [16:0] dist_sat;
  logic [31:0] front_age;
  logic [31:0] rear_age;
  logic [1:0]  fl;
  logic [1:0]  rl;
  logic [16:0] fd;
  logic [16:0] rd;
  logic        won_c;
  logic [1:0]  wl_c;
  logic [16:0] wd_c;
  logic [7:0]  deb_eff;
  logic [16:0] dd_eff;
  logic [8:0]  run_inc;
  logic [FRAME_COUNT_BITS:0] key_c;
  logic        stop_c;
  logic        q_sat;
  logic [9:0]  conf_c;

  assign lvl_sat  = (in_item.sample_level > LVL_DANGER) ? LVL_DANGER : in_item.sample_level;
  assign dist_sat = (in_item.sample_dist_cm > SAFE_DIST_CM) ? SAFE_DIST_CM
                                                            : in_item.sample_dist_cm;
  assign front_age = in_item.time_ms - front_stamp;
  assign rear_age  = in_item.time_ms - rear_stamp;

  assign fl    = front_silent ? LVL_SAFE : front_level;
  assign fd    = front_silent ? SAFE_DIST_CM : front_dist;
  assign rl    = rear_silent ? LVL_SAFE : rear_level;
  assign rd    = rear_silent ? SAFE_DIST_CM : rear_dist;
  assign won_c = (fl > rl) || ((fl == rl) && (fd <= rd));
  assign wl_c  = won_c ? fl : rl;
  assign wd_c  = won_c ? fd : rd;

  assign deb_eff = (debounce_frames == 8'd0) ? 8'd1 : debounce_frames;
  assign dd_eff  = (danger_dist_cm == 17'd0) ? 17'd1 : danger_dist_cm;
  assign run_inc = {1'b0, danger_run} + 9'd1;
  assign key_c   = won_c ? {front_count, 1'b0} : {rear_count, 1'b1};

  assign stop_c = stop_enable && (danger_run >= deb_eff);
  assign q_sat  = quot[Q_W-1] || (quot[Q_W-2:0] > CONF_CLAMP);
  assign conf_c = !stop_c ? 10'd0 : (q_sat ? CONF_CLAMP : PERMILLE - quot[Q_W-2:0]);

  assign sts.div_done = (step_cnt == STEP_W'(DIV_STEPS - 1));
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms      <= TIMEOUT_RST;
      stop_enable     <= 1'b1;
      danger_dist_cm  <= DANGER_RST;
      debounce_frames <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT:  timeout_ms      <= cfg_data[15:0];
        REG_STOP_EN:  stop_enable     <= cfg_data[0];
        REG_DANGER:   danger_dist_cm  <= cfg_data;
        REG_DEBOUNCE: debounce_frames <= cfg_data[7:0];
        default:      stop_enable     <= stop_enable;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_level <= '0;
      front_dist  <= '0;
      front_stamp <= '0;
      front_count <= '0;
      front_seen  <= 1'b0;
      rear_level  <= '0;
      rear_dist   <= '0;
      rear_stamp  <= '0;
      rear_count  <= '0;
      rear_seen   <= 1'b0;
    end else begin
      if (cmd.store_front) begin
        front_level <= lvl_sat;
        front_dist  <= dist_sat;
        front_stamp <= in_item.time_ms;
        front_count <= front_count + 1'b1;
        front_seen  <= 1'b1;
      end
      if (cmd.store_rear) begin
        rear_level <= lvl_sat;
        rear_dist  <= dist_sat;
        rear_stamp <= in_item.time_ms;
        rear_count <= rear_count + 1'b1;
        rear_seen  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      danger_run  <= '0;
      counted_key <= '0;
    end else if (cmd.eval) begin
      if (wl_c == LVL_DANGER) begin
        if (key_c != counted_key) begin
          counted_key <= key_c;
          danger_run  <= (run_inc >= {1'b0, deb_eff}) ? deb_eff : run_inc[7:0];
        end
      end else begin
        danger_run  <= '0;
        counted_key <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      front_silent <= !front_seen || (front_age > {16'd0, timeout_ms});
      rear_silent  <= !rear_seen || (rear_age > {16'd0, timeout_ms});
    end
    if (cmd.eval) begin
      win_level <= wl_c;
      win_dist  <= wd_c;
      front_won <= won_c;
    end
    if (cmd.load) begin
      rem      <= NUM_W'(win_dist) * NUM_W'(PERMILLE) + NUM_W'(dd_eff >> 1);
      divisor  <= {dd_eff, {(NUM_W - 17){1'b0}}};
      quot     <= '0;
      step_cnt <= '0;
    end else if (cmd.step) begin
      if (rem >= divisor) begin
        rem  <= rem - divisor;
        quot <= {quot[Q_W-2:0], 1'b1};
      end else begin
        quot <= {quot[Q_W-2:0], 1'b0};
      end
      divisor  <= divisor >> 1;
      step_cnt <= step_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.fused_level         <= win_level;
      out_item.fused_dist_cm       <= win_dist;
      out_item.warning_flag        <= (win_level != LVL_SAFE);
      out_item.front_chosen        <= front_won;
      out_item.stop_flag           <= stop_c;
      out_item.stop_reason         <= stop_c;
      out_item.confidence_permille <= conf_c;
      out_item.front_silent        <= front_silent;
      out_item.rear_silent         <= rear_silent;
    end
  end

  `DSWF_ASSERT_IMP(a_key_needs_run, counted_key != '0, danger_run != 8'd0, "key without run")
  `DSWF_ASSERT_IMP(a_stop_is_danger, out_valid && out_item.stop_flag, out_item.fused_level == LVL_DANGER, "stop without danger")
endmodule
